[sv/tacf_pkg.sv]
// Shared constants, types and codes of the touch affine calibration fit.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tacf_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  // signed width of every intermediate of the solve
  localparam int WW  = 4 * COORD_BITS + 24;
  // width of the multiplier's second operand (signed)
  localparam int BW  = 2 * COORD_BITS + 12;
  localparam int MCW = $clog2(BW + 1);
  // unsigned width of the divider's remainder and shifted divisor
  localparam int DW  = WW + FRAC_BITS + 36;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCKS = 2'd2;

  localparam logic [15:0] WIDTH_RESET  = 16'd1920;
  localparam logic [15:0] HEIGHT_RESET = 16'd1080;
  localparam logic [6:0]  BLOCKS_RESET = 7'd8;
  localparam logic [6:0]  BLOCKS_MIN   = 7'd3;
  localparam logic [6:0]  BLOCKS_MAX   = 7'd64;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  localparam int STEP_BITS = 6;
  localparam logic [STEP_BITS-1:0] STEP_CHK    = 6'd20;
  localparam logic [STEP_BITS-1:0] STEP_AXIS_X = 6'd22;
  localparam logic [STEP_BITS-1:0] STEP_AXIS_Y = 6'd34;
  localparam logic [STEP_BITS-1:0] STEP_END    = 6'd46;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [WW-1:0]  wide_t;

  typedef struct packed {
    coord_t [3:0] px;
    coord_t [3:0] py;
    logic [15:0]  width;
    logic [15:0]  height;
    logic [6:0]   blocks;
  } job_t;

  typedef enum logic [1:0] {K_MAC, K_CHK, K_DIV, K_END} kind_t;

  typedef enum logic [4:0] {
    S_ZERO, S_PX0, S_PX1, S_PX2, S_PX3, S_PY0, S_PY1, S_PY2, S_PY3,
    S_FOUR, S_SX, S_SY, S_KXX, S_KYY, S_KXY, S_KDET, S_DEN,
    S_PA, S_PB, S_NS, S_T, S_N, S_M, S_SA, S_SB, S_SC
  } src_t;

  // one step of the solve: dst = c +/- a*b, or a divide of a into a slot
  typedef struct packed {
    kind_t      kind;
    src_t       a;
    src_t       b;
    src_t       c;
    logic       sub;
    src_t       dst;
    logic       dbl;
    logic [2:0] slot;
  } step_t;

  typedef enum logic [2:0] {BK_IDLE, BK_ISSUE, BK_MUL, BK_DIV, BK_DONE} bk_state_t;
  typedef enum logic [2:0] {DV_IDLE, DV_CHK, DV_RUN, DV_FIN, DV_DONE} dv_state_t;

endpackage

[sv/tacf_front.sv]
// Front end: configuration registers, point collection, job hand-off.
// Depends on tacf_pkg.
`timescale 1ns / 1ps

module tacf_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr,
  input  logic [tacf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [tacf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                  push,
  output logic                                  full,
  input  logic [15:0]                           raw_x,
  input  logic [15:0]                           raw_y,
  output logic                                  job_push,
  output tacf_pkg::job_t                        job,
  input  logic                                  job_full
);

  logic [15:0]      width;
  logic [15:0]      height;
  logic [6:0]       blocks;
  logic [1:0]       count;
  tacf_pkg::coord_t store_x [3];
  tacf_pkg::coord_t store_y [3];
  tacf_pkg::coord_t cx;
  tacf_pkg::coord_t cy;
  logic             accept;

  assign cx       = tacf_pkg::coord_t'(raw_x);
  assign cy       = tacf_pkg::coord_t'(raw_y);
  assign full     = job_full;
  assign accept   = push && !job_full;
  assign job_push = accept && (count == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= tacf_pkg::WIDTH_RESET;
      height <= tacf_pkg::HEIGHT_RESET;
      blocks <= tacf_pkg::BLOCKS_RESET;
      count  <= 2'd0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          tacf_pkg::CFG_WIDTH:  width  <= cfg_data;
          tacf_pkg::CFG_HEIGHT: height <= cfg_data;
          tacf_pkg::CFG_BLOCKS: blocks <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (accept) count <= count + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count != 2'd3) begin
      store_x[count] <= cx;
      store_y[count] <= cy;
    end
  end

  always_comb begin
    job.px     = {cx, store_x[2], store_x[1], store_x[0]};
    job.py     = {cy, store_y[2], store_y[1], store_y[0]};
    job.width  = width;
    job.height = height;
    job.blocks = blocks;
  end

endmodule

[sv/tacf_queue.sv]
// Two-entry job queue between the front end and the solver.
// Depends on tacf_pkg.
`timescale 1ns / 1ps

module tacf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tacf_pkg::job_t job_in,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output tacf_pkg::job_t job_out
);

  tacf_pkg::job_t mem [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;

  assign full    = (cnt == 2'd2);
  assign valid   = (cnt != 2'd0);
  assign job_out = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      if (push && !pop)      cnt <= cnt + 2'd1;
      else if (pop && !push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= job_in;
  end

endmodule

[sv/tacf_mul.sv]
// Bit-serial signed multiplier, one bit of the narrow operand per cycle.
// Returns a times the magnitude of b, and the sign of b; depends on tacf_pkg.
`timescale 1ns / 1ps

module tacf_mul (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  tacf_pkg::wide_t                a,
  input  logic signed [tacf_pkg::BW-1:0] b,
  output logic                           done,
  output tacf_pkg::wide_t                acc,
  output logic                           neg
);

  tacf_pkg::wide_t            sh;
  logic [tacf_pkg::BW-1:0]    mag;
  logic [tacf_pkg::MCW-1:0]   cnt;
  logic                       busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == tacf_pkg::MCW'(1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == tacf_pkg::MCW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      sh  <= a;
      mag <= b[tacf_pkg::BW-1] ? tacf_pkg::BW'(-b) : tacf_pkg::BW'(b);
      neg <= b[tacf_pkg::BW-1];
      cnt <= tacf_pkg::MCW'(tacf_pkg::BW);
    end else if (busy) begin
      if (mag[0]) acc <= acc + sh;
      sh  <= sh <<< 1;
      mag <= mag >> 1;
      cnt <= cnt - tacf_pkg::MCW'(1);
    end
  end

endmodule

[sv/tacf_div.sv]
// Restoring divider: round(num * 2^FRAC_BITS / den), ties away from zero,
// saturated to 32 bits; one quotient bit per cycle. Depends on tacf_pkg.
`timescale 1ns / 1ps

module tacf_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  tacf_pkg::wide_t num,
  input  tacf_pkg::wide_t den,
  output logic            done,
  output logic [31:0]     res
);

  tacf_pkg::dv_state_t     state;
  tacf_pkg::dv_state_t     state_next;
  logic [tacf_pkg::DW-1:0] a;
  logic [tacf_pkg::DW-1:0] t;
  logic [tacf_pkg::DW-1:0] tn;
  logic [tacf_pkg::WW-1:0] absnum;
  logic [31:0]             q;
  logic [5:0]              cnt;
  logic                    neg;
  logic                    ge;

  assign absnum = num[tacf_pkg::WW-1] ? tacf_pkg::WW'(-num) : tacf_pkg::WW'(num);
  assign tn     = t >> 1;
  assign ge     = (state == tacf_pkg::DV_CHK) ? (a >= t) : (a >= tn);

  always_comb begin
    state_next = state;
    unique case (state)
      tacf_pkg::DV_IDLE: if (start) state_next = tacf_pkg::DV_CHK;
      tacf_pkg::DV_CHK:  state_next = ge ? tacf_pkg::DV_DONE : tacf_pkg::DV_RUN;
      tacf_pkg::DV_RUN:  if (cnt == 6'd1) state_next = tacf_pkg::DV_FIN;
      tacf_pkg::DV_FIN:  state_next = tacf_pkg::DV_DONE;
      tacf_pkg::DV_DONE: state_next = tacf_pkg::DV_IDLE;
      default:           state_next = tacf_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    done = (state == tacf_pkg::DV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tacf_pkg::DV_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      tacf_pkg::DV_IDLE: begin
        if (start) begin
          // remainder carries +den so the truncated quotient rounds half away
          a   <= (tacf_pkg::DW'(absnum) << (tacf_pkg::FRAC_BITS + 1))
                 + tacf_pkg::DW'(unsigned'(den));
          t   <= tacf_pkg::DW'(unsigned'(den)) << 33;
          neg <= num[tacf_pkg::WW-1];
          q   <= '0;
          cnt <= 6'd32;
        end
      end
      tacf_pkg::DV_CHK: begin
        if (ge) res <= neg ? tacf_pkg::Q_MIN : tacf_pkg::Q_MAX;
      end
      tacf_pkg::DV_RUN: begin
        if (ge) a <= a - tn;
        q   <= {q[30:0], ge};
        t   <= tn;
        cnt <= cnt - 6'd1;
      end
      tacf_pkg::DV_FIN: begin
        if (neg) res <= (q > tacf_pkg::Q_MIN) ? tacf_pkg::Q_MIN : (32'd0 - q);
        else     res <= (q > tacf_pkg::Q_MAX) ? tacf_pkg::Q_MAX : q;
      end
      default: ;
    endcase
  end

endmodule

[sv/tacf_back.sv]
// Solver: steps through the normal-equation solve on the shared multiplier
// and divider and holds the result for the consumer. Depends on tacf_pkg,
// tacf_mul and tacf_div.
`timescale 1ns / 1ps

module tacf_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  tacf_pkg::job_t       q_job,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [5:0][31:0]     coef,
  output logic                 singular
);

  tacf_pkg::bk_state_t       state;
  tacf_pkg::bk_state_t       state_next;
  tacf_pkg::job_t            job;
  logic [tacf_pkg::STEP_BITS-1:0] step;
  logic [tacf_pkg::STEP_BITS-1:0] lstep;
  tacf_pkg::step_t           st;
  logic                      axis;
  logic                      out_valid;

  tacf_pkg::wide_t kxx, kyy, kxy, kdet, den, pa, pb, ns, tt;
  tacf_pkg::wide_t px_w [4];
  tacf_pkg::wide_t py_w [4];
  tacf_pkg::wide_t sx, sy, sa, sb, sc, n_w, m_w;
  tacf_pkg::wide_t a_val, b_wide, c_val, wb_val, div_den;
  logic [6:0]      n;

  logic            mul_start, mul_done, mul_neg;
  tacf_pkg::wide_t mul_acc;
  logic            div_start, div_done;
  logic [31:0]     div_res;
  logic            kdet_zero, wb_mul, wb_div, chk_pass, fin;

  function automatic tacf_pkg::step_t mac(tacf_pkg::src_t d, tacf_pkg::src_t sa_,
                                          tacf_pkg::src_t sb_, tacf_pkg::src_t c,
                                          logic s);
    tacf_pkg::step_t r;
    r = '{kind: tacf_pkg::K_MAC, a: sa_, b: sb_, c: c, sub: s, dst: d,
          dbl: 1'b0, slot: 3'd0};
    return r;
  endfunction

  function automatic tacf_pkg::step_t dv(tacf_pkg::src_t nm, logic d2, logic [2:0] sl);
    tacf_pkg::step_t r;
    r = '{kind: tacf_pkg::K_DIV, a: nm, b: tacf_pkg::S_ZERO, c: tacf_pkg::S_ZERO,
          sub: 1'b0, dst: tacf_pkg::S_ZERO, dbl: d2, slot: sl};
    return r;
  endfunction

  function automatic tacf_pkg::src_t pxs(logic [1:0] i);
    tacf_pkg::src_t r;
    case (i)
      2'd0:    r = tacf_pkg::S_PX0;
      2'd1:    r = tacf_pkg::S_PX1;
      2'd2:    r = tacf_pkg::S_PX2;
      default: r = tacf_pkg::S_PX3;
    endcase
    return r;
  endfunction

  function automatic tacf_pkg::src_t pys(logic [1:0] i);
    tacf_pkg::src_t r;
    case (i)
      2'd0:    r = tacf_pkg::S_PY0;
      2'd1:    r = tacf_pkg::S_PY1;
      2'd2:    r = tacf_pkg::S_PY2;
      default: r = tacf_pkg::S_PY3;
    endcase
    return r;
  endfunction

  function automatic tacf_pkg::wide_t src_val(tacf_pkg::src_t s);
    tacf_pkg::wide_t r;
    case (s)
      tacf_pkg::S_PX0:  r = px_w[0];
      tacf_pkg::S_PX1:  r = px_w[1];
      tacf_pkg::S_PX2:  r = px_w[2];
      tacf_pkg::S_PX3:  r = px_w[3];
      tacf_pkg::S_PY0:  r = py_w[0];
      tacf_pkg::S_PY1:  r = py_w[1];
      tacf_pkg::S_PY2:  r = py_w[2];
      tacf_pkg::S_PY3:  r = py_w[3];
      tacf_pkg::S_FOUR: r = tacf_pkg::wide_t'(4);
      tacf_pkg::S_SX:   r = sx;
      tacf_pkg::S_SY:   r = sy;
      tacf_pkg::S_KXX:  r = kxx;
      tacf_pkg::S_KYY:  r = kyy;
      tacf_pkg::S_KXY:  r = kxy;
      tacf_pkg::S_KDET: r = kdet;
      tacf_pkg::S_DEN:  r = den;
      tacf_pkg::S_PA:   r = pa;
      tacf_pkg::S_PB:   r = pb;
      tacf_pkg::S_NS:   r = ns;
      tacf_pkg::S_T:    r = tt;
      tacf_pkg::S_N:    r = n_w;
      tacf_pkg::S_M:    r = m_w;
      tacf_pkg::S_SA:   r = sa;
      tacf_pkg::S_SB:   r = sb;
      tacf_pkg::S_SC:   r = sc;
      default:          r = '0;
    endcase
    return r;
  endfunction

  // operands straight from the current job
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px_w[i] = tacf_pkg::wide_t'(job.px[i]);
      py_w[i] = tacf_pkg::wide_t'(job.py[i]);
    end
    sx = px_w[0] + px_w[1] + px_w[2] + px_w[3];
    sy = py_w[0] + py_w[1] + py_w[2] + py_w[3];
    if (job.blocks < tacf_pkg::BLOCKS_MIN)      n = tacf_pkg::BLOCKS_MIN;
    else if (job.blocks > tacf_pkg::BLOCKS_MAX) n = tacf_pkg::BLOCKS_MAX;
    else                                        n = job.blocks;
    n_w = tacf_pkg::wide_t'(n);
    m_w = tacf_pkg::wide_t'(n - 7'd2);
    if (axis) begin
      sa = px_w[2] + px_w[3] - px_w[0] - px_w[1];
      sb = py_w[2] + py_w[3] - py_w[0] - py_w[1];
      sc = tacf_pkg::wide_t'(24'(job.height) * 24'(n - 7'd2)) <<< 1;
    end else begin
      sa = px_w[1] + px_w[3] - px_w[0] - px_w[2];
      sb = py_w[1] + py_w[3] - py_w[0] - py_w[2];
      sc = tacf_pkg::wide_t'(24'(job.width) * 24'(n - 7'd2)) <<< 1;
    end
  end

  // step decoder
  always_comb begin
    axis  = (step >= tacf_pkg::STEP_AXIS_Y);
    lstep = axis ? step - tacf_pkg::STEP_AXIS_Y : step - tacf_pkg::STEP_AXIS_X;
    st    = '{kind: tacf_pkg::K_END, a: tacf_pkg::S_ZERO, b: tacf_pkg::S_ZERO,
              c: tacf_pkg::S_ZERO, sub: 1'b0, dst: tacf_pkg::S_ZERO, dbl: 1'b0,
              slot: 3'd0};
    if (step < 6'd4) begin
      st = mac(tacf_pkg::S_KXX, pxs(step[1:0]), pxs(step[1:0]), tacf_pkg::S_KXX, 1'b0);
    end else if (step < 6'd8) begin
      st = mac(tacf_pkg::S_KYY, pys(step[1:0]), pys(step[1:0]), tacf_pkg::S_KYY, 1'b0);
    end else if (step < 6'd12) begin
      st = mac(tacf_pkg::S_KXY, pxs(step[1:0]), pys(step[1:0]), tacf_pkg::S_KXY, 1'b0);
    end else if (step < tacf_pkg::STEP_AXIS_X) begin
      unique case (step)
        6'd12: st = mac(tacf_pkg::S_KXX, tacf_pkg::S_KXX, tacf_pkg::S_FOUR,
                        tacf_pkg::S_ZERO, 1'b0);
        6'd13: st = mac(tacf_pkg::S_KXX, tacf_pkg::S_SX, tacf_pkg::S_SX,
                        tacf_pkg::S_KXX, 1'b1);
        6'd14: st = mac(tacf_pkg::S_KYY, tacf_pkg::S_KYY, tacf_pkg::S_FOUR,
                        tacf_pkg::S_ZERO, 1'b0);
        6'd15: st = mac(tacf_pkg::S_KYY, tacf_pkg::S_SY, tacf_pkg::S_SY,
                        tacf_pkg::S_KYY, 1'b1);
        6'd16: st = mac(tacf_pkg::S_KXY, tacf_pkg::S_KXY, tacf_pkg::S_FOUR,
                        tacf_pkg::S_ZERO, 1'b0);
        6'd17: st = mac(tacf_pkg::S_KXY, tacf_pkg::S_SX, tacf_pkg::S_SY,
                        tacf_pkg::S_KXY, 1'b1);
        6'd18: st = mac(tacf_pkg::S_KDET, tacf_pkg::S_KXX, tacf_pkg::S_KYY,
                        tacf_pkg::S_ZERO, 1'b0);
        6'd19: st = mac(tacf_pkg::S_KDET, tacf_pkg::S_KXY, tacf_pkg::S_KXY,
                        tacf_pkg::S_KDET, 1'b1);
        tacf_pkg::STEP_CHK: st.kind = tacf_pkg::K_CHK;
        6'd21: st = mac(tacf_pkg::S_DEN, tacf_pkg::S_KDET, tacf_pkg::S_N,
                        tacf_pkg::S_ZERO, 1'b0);
        default: ;
      endcase
    end else if (step < tacf_pkg::STEP_END) begin
      unique case (lstep[3:0])
        4'd0:  st = mac(tacf_pkg::S_PA, tacf_pkg::S_KYY, tacf_pkg::S_SA,
                        tacf_pkg::S_ZERO, 1'b0);
        4'd1:  st = mac(tacf_pkg::S_PA, tacf_pkg::S_KXY, tacf_pkg::S_SB,
                        tacf_pkg::S_PA, 1'b1);
        4'd2:  st = mac(tacf_pkg::S_PB, tacf_pkg::S_KXX, tacf_pkg::S_SB,
                        tacf_pkg::S_ZERO, 1'b0);
        4'd3:  st = mac(tacf_pkg::S_PB, tacf_pkg::S_KXY, tacf_pkg::S_SA,
                        tacf_pkg::S_PB, 1'b1);
        4'd4:  st = mac(tacf_pkg::S_NS, tacf_pkg::S_PA, tacf_pkg::S_SX,
                        tacf_pkg::S_ZERO, 1'b0);
        4'd5:  st = mac(tacf_pkg::S_NS, tacf_pkg::S_PB, tacf_pkg::S_SY,
                        tacf_pkg::S_NS, 1'b0);
        4'd6:  st = mac(tacf_pkg::S_T, tacf_pkg::S_NS, tacf_pkg::S_M,
                        tacf_pkg::S_DEN, 1'b1);
        4'd7:  st = mac(tacf_pkg::S_NS, tacf_pkg::S_PA, tacf_pkg::S_SC,
                        tacf_pkg::S_ZERO, 1'b0);
        4'd8:  st = dv(tacf_pkg::S_NS, 1'b0, axis ? 3'd3 : 3'd0);
        4'd9:  st = mac(tacf_pkg::S_NS, tacf_pkg::S_PB, tacf_pkg::S_SC,
                        tacf_pkg::S_ZERO, 1'b0);
        4'd10: st = dv(tacf_pkg::S_NS, 1'b0, axis ? 3'd4 : 3'd1);
        4'd11: st = dv(tacf_pkg::S_T, 1'b1, axis ? 3'd5 : 3'd2);
        default: ;
      endcase
    end
  end

  always_comb begin
    a_val   = src_val(st.a);
    b_wide  = src_val(st.b);
    c_val   = src_val(st.c);
    wb_val  = (st.sub ^ mul_neg) ? c_val - mul_acc : c_val + mul_acc;
    div_den = st.dbl ? (den <<< 1) : den;
  end

  assign kdet_zero = (kdet == '0);

  tacf_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (a_val),
    .b     (b_wide[tacf_pkg::BW-1:0]),
    .done  (mul_done),
    .acc   (mul_acc),
    .neg   (mul_neg)
  );

  tacf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (a_val),
    .den   (div_den),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      tacf_pkg::BK_IDLE:  if (q_valid && !out_valid) state_next = tacf_pkg::BK_ISSUE;
      tacf_pkg::BK_ISSUE: begin
        unique case (st.kind)
          tacf_pkg::K_MAC: state_next = tacf_pkg::BK_MUL;
          tacf_pkg::K_DIV: state_next = tacf_pkg::BK_DIV;
          tacf_pkg::K_CHK: if (kdet_zero) state_next = tacf_pkg::BK_DONE;
          default:         state_next = tacf_pkg::BK_DONE;
        endcase
      end
      tacf_pkg::BK_MUL:   if (mul_done) state_next = tacf_pkg::BK_ISSUE;
      tacf_pkg::BK_DIV:   if (div_done) state_next = tacf_pkg::BK_ISSUE;
      tacf_pkg::BK_DONE:  state_next = tacf_pkg::BK_IDLE;
      default:            state_next = tacf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == tacf_pkg::BK_IDLE) && q_valid && !out_valid;
    mul_start = (state == tacf_pkg::BK_ISSUE) && (st.kind == tacf_pkg::K_MAC);
    div_start = (state == tacf_pkg::BK_ISSUE) && (st.kind == tacf_pkg::K_DIV);
    chk_pass  = (state == tacf_pkg::BK_ISSUE) && (st.kind == tacf_pkg::K_CHK);
    wb_mul    = (state == tacf_pkg::BK_MUL) && mul_done;
    wb_div    = (state == tacf_pkg::BK_DIV) && div_done;
    fin       = (state == tacf_pkg::BK_DONE);
    empty     = !out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tacf_pkg::BK_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (fin)                            out_valid <= 1'b1;
      else if (pop && out_valid)          out_valid <= 1'b0;
      if (q_pop)                          step <= '0;
      else if (wb_mul || wb_div || (chk_pass && !kdet_zero))
        step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job      <= q_job;
      kxx      <= '0;
      kyy      <= '0;
      kxy      <= '0;
      coef     <= '0;
      singular <= 1'b0;
    end
    if (chk_pass && kdet_zero) singular <= 1'b1;
    if (wb_div) coef[st.slot] <= div_res;
    if (wb_mul) begin
      case (st.dst)
        tacf_pkg::S_KXX:  kxx  <= wb_val;
        tacf_pkg::S_KYY:  kyy  <= wb_val;
        tacf_pkg::S_KXY:  kxy  <= wb_val;
        tacf_pkg::S_KDET: kdet <= wb_val;
        tacf_pkg::S_DEN:  den  <= wb_val;
        tacf_pkg::S_PA:   pa   <= wb_val;
        tacf_pkg::S_PB:   pb   <= wb_val;
        tacf_pkg::S_NS:   ns   <= wb_val;
        tacf_pkg::S_T:    tt   <= wb_val;
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_mul_done_owned: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> state == tacf_pkg::BK_MUL)
    else $error("multiplier finished outside a multiply step");
  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == tacf_pkg::BK_DIV)
    else $error("divider finished outside a divide step");
  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    state != tacf_pkg::BK_IDLE |-> !out_valid)
    else $error("result shown while a solve is in flight");
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    fin |=> out_valid)
    else $error("finished solve not shown");
`endif

endmodule

[sv/touch_affine_calibration_fit.sv]
// Top level of the touch affine calibration fit.
// Depends on tacf_pkg, tacf_front, tacf_queue and tacf_back.
`timescale 1ns / 1ps

// Push four touched points (upper-left, upper-right, lower-left,
// lower-right); a point is taken while full is low and the fourth hands a
// solve job to a two-deep queue, so up to two more point sets can be
// collected while a solve runs. Screen size and block count are sampled with
// the fourth point. A solve runs 39 steps on one shared bit-serial
// multiplier plus six restoring divides (a divide that saturates skips its
// bit loop); a singular point set finishes at the determinant check.
// The result then waits on the output until popped; coefficients are signed
// Q16.16, saturated, and all zero with singular set for collinear points.
module touch_affine_calibration_fit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr,
  input  logic [tacf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tacf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                push,
  output logic                                full,
  input  logic [15:0]                         raw_x,
  input  logic [15:0]                         raw_y,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [31:0]                  coef_xx,
  output logic signed [31:0]                  coef_xy,
  output logic signed [31:0]                  offset_x,
  output logic signed [31:0]                  coef_yx,
  output logic signed [31:0]                  coef_yy,
  output logic signed [31:0]                  offset_y,
  output logic                                singular
);

  logic             job_push;
  logic             job_full;
  logic             job_valid;
  logic             job_pop;
  tacf_pkg::job_t   job_in;
  tacf_pkg::job_t   job_out;
  logic [5:0][31:0] coef;

  tacf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .raw_x     (raw_x),
    .raw_y     (raw_y),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  tacf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .job_in  (job_in),
    .full    (job_full),
    .pop     (job_pop),
    .valid   (job_valid),
    .job_out (job_out)
  );

  tacf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (job_valid),
    .q_job    (job_out),
    .q_pop    (job_pop),
    .empty    (empty),
    .pop      (pop),
    .coef     (coef),
    .singular (singular)
  );

  assign coef_xx  = signed'(coef[0]);
  assign coef_xy  = signed'(coef[1]);
  assign offset_x = signed'(coef[2]);
  assign coef_yx  = signed'(coef[3]);
  assign coef_yy  = signed'(coef[4]);
  assign offset_y = signed'(coef[5]);

endmodule

[tb/touch_affine_calibration_fit_chk.sv]
// Checker for the touch affine calibration fit: tracks register writes and
// points, predicts each fit result and compares it with what is popped.
// Depends on tacf_pkg.
`timescale 1ns / 1ps

module touch_affine_calibration_fit_chk
  import tacf_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      push,
  input  logic                      full,
  input  logic [15:0]               raw_x,
  input  logic [15:0]               raw_y,
  input  logic                      empty,
  input  logic                      pop,
  input  logic [31:0]               coef_xx,
  input  logic [31:0]               coef_xy,
  input  logic [31:0]               offset_x,
  input  logic [31:0]               coef_yx,
  input  logic [31:0]               coef_yy,
  input  logic [31:0]               offset_y,
  input  logic                      singular,
  input  logic                      end_check,
  output int                        pending,
  output int                        fail_count
);

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    logic [5:0][31:0] coef;
    logic             sing;
  } fit_t;

  fit_t        fit_q[$];
  logic [15:0] width_r, height_r;
  logic [6:0]  blocks_r;
  coord_t      pt_x[4], pt_y[4];
  logic [1:0]  pt_cnt;
  logic        end_done;
  int          solves;

  assign pending = fit_q.size();

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  // round(num * 2^FRAC_BITS / den), ties away from zero, saturated; den > 0
  function automatic logic [31:0] q_round(input big_t num, input big_t den);
    logic [255:0] mag, a, q;
    logic         neg;
    neg = num < 0;
    mag = neg ? -num : num;
    a   = (mag << (FRAC_BITS + 1)) + den;
    q   = a / (den << 1);
    if (!neg) return (q > 256'h7FFF_FFFF) ? Q_MAX : q[31:0];
    return (q > 256'h8000_0000) ? Q_MIN : 32'd0 - q[31:0];
  endfunction

  function automatic void fit_axis(input big_t scale, sa, sb, kxx, kxy, kyy,
                                   sx, sy, den, m,
                                   output logic [31:0] ga, gb, off);
    big_t pa, pb, nsum;
    pa   = kyy * sa - kxy * sb;
    pb   = kxx * sb - kxy * sa;
    nsum = pa * sx + pb * sy;
    ga   = q_round(scale * pa, den);
    gb   = q_round(scale * pb, den);
    off  = q_round(den - m * nsum, den <<< 1);
  endfunction

  function automatic fit_t solve_fit();
    fit_t r;
    big_t px[4], py[4];
    big_t sx, sy, sxx, syy, sxy, kxx, kyy, kxy, kdet, den, n, m;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    r  = '0;
    for (int i = 0; i < 4; i++) begin
      px[i] = big_t'(pt_x[i]);
      py[i] = big_t'(pt_y[i]);
      sx  += px[i];
      sy  += py[i];
      sxx += px[i] * px[i];
      syy += py[i] * py[i];
      sxy += px[i] * py[i];
    end
    kxx  = 4 * sxx - sx * sx;
    kyy  = 4 * syy - sy * sy;
    kxy  = 4 * sxy - sx * sy;
    kdet = kxx * kyy - kxy * kxy;
    if (kdet == 0) begin
      r.sing = 1'b1;
      return r;
    end
    n = big_t'(blocks_r);
    if (n < BLOCKS_MIN) n = BLOCKS_MIN;
    if (n > BLOCKS_MAX) n = BLOCKS_MAX;
    m   = n - 2;
    den = n * kdet;
    fit_axis(2 * big_t'(width_r) * m, px[1] + px[3] - px[0] - px[2],
             py[1] + py[3] - py[0] - py[2], kxx, kxy, kyy, sx, sy, den, m,
             r.coef[0], r.coef[1], r.coef[2]);
    fit_axis(2 * big_t'(height_r) * m, px[2] + px[3] - px[0] - px[1],
             py[2] + py[3] - py[0] - py[1], kxx, kxy, kyy, sx, sy, den, m,
             r.coef[3], r.coef[4], r.coef[5]);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    end_done   = 1'b0;
    solves     = 0;
  end

  always @(posedge clk) begin
    fit_t got, exp_fit;
    if (rst) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      blocks_r <= BLOCKS_RESET;
      pt_cnt   <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_WIDTH:  width_r  <= cfg_data;
          CFG_HEIGHT: height_r <= cfg_data;
          CFG_BLOCKS: blocks_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        pt_x[pt_cnt] = raw_x;
        pt_y[pt_cnt] = raw_y;
        if (pt_cnt == 2'd3) begin
          fit_q.push_back(solve_fit());
          solves++;
        end
        pt_cnt <= pt_cnt + 2'd1;
      end
      if (pop && !empty) begin
        got.coef = {offset_y, coef_yy, coef_yx, offset_x, coef_xy, coef_xx};
        got.sing = singular;
        if (fit_q.size() == 0) begin
          report("result popped with none expected");
        end else begin
          exp_fit = fit_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (got.coef[i] !== exp_fit.coef[i])
              report($sformatf("coefficient %0d got %h want %h", i, got.coef[i],
                               exp_fit.coef[i]));
          if (got.sing !== exp_fit.sing)
            report($sformatf("singular got %b want %b", got.sing, exp_fit.sing));
        end
      end
      if (end_check && !end_done) begin
        end_done = 1'b1;
        if (fit_q.size() != 0)
          report($sformatf("%0d results never arrived", fit_q.size()));
      end
    end
  end

endmodule

[tb/touch_affine_calibration_fit_tb.sv]
// Testbench top for the touch affine calibration fit: drives point sets and
// register settings, pops results, and gives the verdict.
// Depends on tacf_pkg, touch_affine_calibration_fit and its checker.
`timescale 1ns / 1ps

module touch_affine_calibration_fit_tb;
  import tacf_pkg::*;

  localparam int HOLD_CYCLES = 2500;   // one solve plus margin
  localparam int STALL_LIMIT = 60000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      push = 1'b0;
  logic                      full;
  logic [15:0]               raw_x = '0, raw_y = '0;
  logic                      empty;
  logic                      pop = 1'b0;
  logic signed [31:0]        coef_xx, coef_xy, offset_x, coef_yx, coef_yy, offset_y;
  logic                      singular;
  logic                      end_check = 1'b0;
  logic                      no_gaps = 1'b0;
  int                        pending, fail_count, stall_cnt = 0;
  int                        sets_sent = 0, settings_used = 0;

  always #6 clk = ~clk;

  touch_affine_calibration_fit u_top (.*);

  touch_affine_calibration_fit_chk u_chk (.*);

  always @(negedge clk)
    pop <= (no_gaps || $urandom_range(99) >= 19);

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_wr) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [15:0] clip(input int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // called at a falling edge; returns at a falling edge with push still high
  task automatic send_point(input logic [15:0] x, input logic [15:0] y);
    while (!no_gaps && $urandom_range(99) < 19) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push  <= 1'b1;
    raw_x <= x;
    raw_y <= y;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_set(input int x0, y0, x1, y1, x2, y2, x3, y3);
    send_point(clip(x0), clip(y0));
    send_point(clip(x1), clip(y1));
    send_point(clip(x2), clip(y2));
    send_point(clip(x3), clip(y3));
    sets_sent++;
  endtask

  // pause until every result is back and the solver has gone quiet
  task automatic drain();
    push <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (HOLD_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(input logic [15:0] w, h, input logic [15:0] b);
    cfg_wr    <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_index <= CFG_BLOCKS;
    cfg_data  <= b;
    @(negedge clk);
    cfg_wr <= 1'b0;
    @(negedge clk);
    settings_used++;
  endtask

  task automatic random_set();
    int kind, x0, y0, dx, dy, j;
    kind = $urandom_range(99);
    x0 = $urandom_range(40000);
    y0 = $urandom_range(40000);
    dx = $urandom_range(1, 25535);
    dy = $urandom_range(1, 25535);
    j  = $urandom_range(300);
    if (kind < 60) begin
      // corners in touch order with some jitter
      send_set(x0 + $urandom_range(j) - j / 2, y0 + $urandom_range(j) - j / 2,
               x0 + dx + $urandom_range(j) - j / 2, y0 + $urandom_range(j) - j / 2,
               x0 + $urandom_range(j) - j / 2, y0 + dy + $urandom_range(j) - j / 2,
               x0 + dx + $urandom_range(j) - j / 2, y0 + dy + $urandom_range(j) - j / 2);
    end else if (kind < 75) begin
      send_set($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
               $urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
               $urandom_range(65535), $urandom_range(65535));
    end else if (kind < 85) begin
      // tiny spread drives the gains into saturation
      dx = $urandom_range(1, 3);
      dy = $urandom_range(1, 3);
      send_set(x0, y0, x0 + dx, y0, x0, y0 + dy, x0 + dx, y0 + dy);
    end else if (kind < 93) begin
      dx = $urandom_range(5000);
      dy = $urandom_range(5000);
      send_set(x0, y0, x0 + dx, y0 + dy, x0 + 2 * dx, y0 + 2 * dy,
               x0 + 3 * dx, y0 + 3 * dy);
    end else begin
      send_set(x0, y0, x0, y0, x0 + dx * (kind & 1), y0, x0, y0);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // default registers: exact targets, extremes, mirror, singular, saturation
    send_set(240, 135, 1680, 135, 240, 945, 1680, 945);
    send_set(0, 0, 65535, 0, 0, 65535, 65535, 65535);
    send_set(65535, 65535, 0, 65535, 65535, 0, 0, 0);
    send_set(65535, 0, 65535, 0, 65535, 0, 65535, 0);
    send_set(0, 0, 100, 100, 200, 200, 300, 300);
    send_set(1000, 1000, 1001, 1000, 1000, 1001, 1001, 1001);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_regs(16'd0, 16'd0, 16'd0);
        1: set_regs(16'hFFFF, 16'hFFFF, 16'd127);
        2: set_regs(16'd1, 16'd1, 16'd64);
        3: set_regs(16'd1, 16'hFFFF, 16'd2);
        4: set_regs(16'd800, 16'd480, 16'd3);
        default: set_regs($urandom_range(65535), $urandom_range(65535),
                          $urandom_range(127));
      endcase
      no_gaps <= (ph == 5);
      for (int s = 0; s < 50; s++) random_set();
      drain();
    end

    no_gaps   <= 1'b0;
    end_check <= 1'b1;
    repeat (2) @(negedge clk);
    $display("tb: %0d point sets over %0d register settings (plus reset defaults)",
             sets_sent, settings_used);
    $display("tb: covered singular, saturating and clamped block-count fits");
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
sv/tacf_pkg.sv
sv/tacf_front.sv
sv/tacf_queue.sv
sv/tacf_mul.sv
sv/tacf_div.sv
sv/tacf_back.sv
sv/touch_affine_calibration_fit.sv
tb/touch_affine_calibration_fit_chk.sv
tb/touch_affine_calibration_fit_tb.sv
